// ===== rtl/sq8_pkg.sv =====
// shared types, constants and codes for the per-dimension sq8 codec
`default_nettype none
package sq8_pkg;

    // item field widths
    localparam int DIM_W  = 8;
    localparam int VAL_W  = 32;
    localparam int CODE_W = 8;
    localparam int ACT_W  = 2;

    // default number of dimensions
    localparam int SQ8_DIMS_DEFAULT = 256;

    // action codes
    localparam logic [ACT_W-1:0] ACT_OBSERVE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FINALISE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUANT    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DEQUANT  = 2'd3;

    // q16.16 constants; HALF_FRAC is one half of a 32-bit fraction
    localparam logic [VAL_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [VAL_W-1:0] MIN_RESET = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] MAX_RESET = 32'h8000_0000;
    localparam logic [VAL_W-1:0] INT_MAX   = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] HALF_FRAC = 32'h8000_0000;

    // shared divider geometry: 40-bit dividend, 32-bit divisor
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // one table row
    typedef struct packed {
        logic [VAL_W-1:0] inv;
        logic [VAL_W-1:0] scale;
        logic [VAL_W-1:0] max;
        logic [VAL_W-1:0] min;
    } dim_entry_t;

    localparam dim_entry_t ENTRY_RESET = '{
        inv:   Q_ONE,
        scale: Q_ONE,
        max:   MAX_RESET,
        min:   MIN_RESET
    };

    // table write request
    typedef struct packed {
        logic             en;
        logic [DIM_W-1:0] dim;
        dim_entry_t       entry;
    } tbl_wr_t;

    // divider request and response
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/per_dim_min_max_sq8_codec.sv =====
// Per-dimension min/max sq8 codec, one item at a time under a small sequencer.
// Observe, finalise of an empty range, quantise at or below min and an out-of-range
// dimension pass EXEC then DONE; multiply items pass EXEC, MUL, FIN and DONE.
// Positive-range finalise waits in DIV_INV for one 40-step pass of the shared divider.
// s_tready returns with m_tvalid, once DONE finds the output free, so items never overlap.
// aresetn (sync) clears the table valid bits, so every row reads as its reset value.
`default_nettype none
module per_dim_min_max_sq8_codec
    import sq8_pkg::*;
#(
    parameter int DIMS = SQ8_DIMS_DEFAULT
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: fixed_bounds
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // dim_index[7:0], value_in[39:8], code_in[47:40]
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // code_out[7:0], value_out[39:8]
    output logic [0:0]       m_tuser    // range_err[0]
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_DIV_INV = 3'd2;
    localparam logic [2:0] ST_MUL     = 3'd4;
    localparam logic [2:0] ST_FIN     = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic              fixed_bounds_reg;
    logic [ACT_W-1:0]  act_reg;
    logic [DIM_W-1:0]  dim_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [CODE_W-1:0] code_reg;
    logic              in_range_reg;
    logic [VAL_W-1:0]  op_a_reg, op_b_reg;
    logic [2*VAL_W-1:0] prod_reg;
    logic [VAL_W:0]    scl_t_reg;
    logic [VAL_W-1:0]  scl_q_reg;
    logic [CODE_W-1:0] res_code_reg;
    logic [VAL_W-1:0]  res_val_reg;
    logic              res_oor_reg;
    logic              m_valid_reg;
    logic [CODE_W-1:0] m_code_reg;
    logic [VAL_W-1:0]  m_val_reg;
    logic              m_oor_reg;

    logic              accept;
    logic              out_free;
    dim_entry_t        ent;
    tbl_wr_t           tbl_wr;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic [VAL_W:0]    diff_w;
    logic [VAL_W:0]    range_w;
    logic              range_pos;
    logic              diff_pos;
    logic              v_lt_min, v_gt_max;
    logic [VAL_W-1:0]  obs_min, obs_max;
    logic              round_up;
    logic [VAL_W:0]    q_rnd;
    logic [CODE_W-1:0] q_code;
    logic [VAL_W+9:0]  dq_sum;
    logic [VAL_W-1:0]  dq_val;
    logic [VAL_W-1:0]  inv_sat;
    logic [VAL_W-1:0]  scl_val;
    logic              in_range_w;

    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign in_range_w = (32'(s_tdata[DIM_W-1:0]) < 32'(DIMS));

    // table and shared divider
    sq8_table #(.DIMS(DIMS)) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_dim   (s_tdata[DIM_W-1:0]),
        .rd_entry (ent),
        .wr       (tbl_wr)
    );

    sq8_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // signed compares and differences on the stored bounds
    always_comb begin
        diff_w    = {val_reg[VAL_W-1], val_reg} - {ent.min[VAL_W-1], ent.min};
        range_w   = {ent.max[VAL_W-1], ent.max} - {ent.min[VAL_W-1], ent.min};
        range_pos = !range_w[VAL_W] && (range_w != '0);
        diff_pos  = !diff_w[VAL_W] && (diff_w != '0);
        v_lt_min  = $signed(val_reg) < $signed(ent.min);
        v_gt_max  = $signed(val_reg) > $signed(ent.max);
        obs_min   = v_lt_min ? val_reg : ent.min;
        obs_max   = v_gt_max ? val_reg : ent.max;
        inv_sat   = (div_rsp.quot[DIV_NUM_W-1:VAL_W] != '0) ? '1 : div_rsp.quot[VAL_W-1:0];
    end

    // rounding and clamping of the product, dequantize sum, scale by 255
    always_comb begin
        round_up = (prod_reg[VAL_W-1:0] > HALF_FRAC) ||
                   ((prod_reg[VAL_W-1:0] == HALF_FRAC) && prod_reg[VAL_W]);
        q_rnd    = {1'b0, prod_reg[2*VAL_W-1:VAL_W]} + (VAL_W+1)'(round_up);
        q_code   = (q_rnd > (VAL_W+1)'(255)) ? CODE_W'(255) : q_rnd[CODE_W-1:0];
        dq_sum   = {{10{ent.min[VAL_W-1]}}, ent.min} + {2'b00, prod_reg[VAL_W+7:0]};
        dq_val   = ($signed(dq_sum) > $signed({10'd0, INT_MAX})) ? INT_MAX
                                                                 : dq_sum[VAL_W-1:0];
        scl_val  = scl_q_reg + VAL_W'(scl_t_reg == (VAL_W+1)'(255));
    end

    // sequencer, divider requests and table writes
    always_comb begin
        state_next      = state_reg;
        div_req.start   = 1'b0;
        div_req.num     = {8'd255, {VAL_W{1'b0}}} + DIV_NUM_W'(range_w[VAL_W-1:1]);
        div_req.den     = range_w[VAL_W-1:0];
        tbl_wr.en       = 1'b0;
        tbl_wr.dim      = dim_reg;
        tbl_wr.entry    = ent;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                if (in_range_reg) begin
                    unique case (act_reg)
                        ACT_OBSERVE: begin
                            tbl_wr.en        = !fixed_bounds_reg;
                            tbl_wr.entry.min = obs_min;
                            tbl_wr.entry.max = obs_max;
                        end
                        ACT_FINALISE: begin
                            if (range_pos) begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV_INV;
                            end else begin
                                tbl_wr.en          = 1'b1;
                                tbl_wr.entry.scale = Q_ONE;
                                tbl_wr.entry.inv   = Q_ONE;
                            end
                        end
                        ACT_QUANT: begin
                            if (diff_pos) begin
                                state_next = ST_MUL;
                            end
                        end
                        ACT_DEQUANT: begin
                            state_next = ST_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV_INV: begin
                if (div_rsp.done) begin
                    tbl_wr.en          = 1'b1;
                    tbl_wr.entry.scale = scl_val;
                    tbl_wr.entry.inv   = inv_sat;
                    state_next         = ST_DONE;
                end
            end
            ST_MUL: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            fixed_bounds_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                fixed_bounds_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item capture, operands, product and results
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg      <= s_tuser;
            dim_reg      <= s_tdata[DIM_W-1:0];
            val_reg      <= s_tdata[DIM_W+VAL_W-1:DIM_W];
            code_reg     <= s_tdata[DIM_W+VAL_W+CODE_W-1:DIM_W+VAL_W];
            in_range_reg <= in_range_w;
        end
        if (state_reg == ST_EXEC) begin
            res_code_reg <= '0;
            res_val_reg  <= '0;
            res_oor_reg  <= in_range_reg && (act_reg == ACT_QUANT) && fixed_bounds_reg &&
                            (v_lt_min || v_gt_max);
            scl_t_reg    <= {1'b0, range_w[VAL_W-1:0]} + (VAL_W+1)'(127);
            scl_q_reg    <= '0;
            if (act_reg == ACT_DEQUANT) begin
                op_a_reg <= ent.scale;
                op_b_reg <= VAL_W'(code_reg);
            end else begin
                op_a_reg <= diff_w[VAL_W-1:0];
                op_b_reg <= ent.inv;
            end
        end
        // divide by 255 as 256a + b = 255a + (a + b), one fold per cycle beside the divider
        if (state_reg == ST_DIV_INV && scl_t_reg[VAL_W:8] != '0) begin
            scl_q_reg <= scl_q_reg + VAL_W'(scl_t_reg[VAL_W:8]);
            scl_t_reg <= (VAL_W+1)'(scl_t_reg[VAL_W:8]) + (VAL_W+1)'(scl_t_reg[7:0]);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= op_a_reg * op_b_reg;
        end
        if (state_reg == ST_FIN) begin
            if (act_reg == ACT_DEQUANT) begin
                res_val_reg <= dq_val;
            end else begin
                res_code_reg <= q_code;
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            m_code_reg <= res_code_reg;
            m_val_reg  <= res_val_reg;
            m_oor_reg  <= res_oor_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && aresetn;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_val_reg, m_code_reg};
    assign m_tuser  = m_oor_reg;

endmodule
`default_nettype wire

// ===== rtl/sq8_div.sv =====
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module sq8_div
    import sq8_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 ge;

    // one shift-compare-subtract step
    always_comb begin
        rem_sh    = {rem_reg, num_reg[DIV_NUM_W-1]};
        ge        = (rem_sh >= {1'b0, den_reg});
        rem_next  = rem_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next = '0;
            num_next = req.num;
            cnt_next = DIV_CNT_W'(DIV_NUM_W);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DEN_W-1:0];
            num_next  = {num_reg[DIV_NUM_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        if (req.start) begin
            den_reg <= req.den;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule
`default_nettype wire

// ===== rtl/sq8_table.sv =====
// per-dimension min, max, scale and inverse table with per-row valid bits
`default_nettype none
module sq8_table
    import sq8_pkg::*;
#(
    parameter int DIMS = SQ8_DIMS_DEFAULT
)
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [DIM_W-1:0] rd_dim,
    output dim_entry_t            rd_entry,
    input  wire tbl_wr_t          wr
);

    localparam int MEM_DEPTH = (DIMS < (1 << DIM_W)) ? DIMS : (1 << DIM_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    dim_entry_t            mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]  valid_reg;
    dim_entry_t            rd_data_reg;
    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     raddr;
    logic [ADDR_W-1:0]     waddr;

    assign raddr = rd_dim[ADDR_W-1:0];
    assign waddr = wr.dim[ADDR_W-1:0];

    // row storage, registered read
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[waddr] <= wr.entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[raddr];
        end
    end

    // valid bits, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    // unwritten rows read as reset values
    assign rd_entry = rd_valid_reg ? rd_data_reg : ENTRY_RESET;

endmodule
`default_nettype wire

// ===== rtl/sq8_checker.sv =====
// port-level checks for the sq8 codec, bound to the top level
`default_nettype none
module sq8_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one item in flight: ready drops after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // out of range only comes with a quantize result, never a value
    a_oor_no_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[39:8] == 32'd0)
        else $error("out of range flagged on a dequantize result");

    // a code and a value never come together
    a_code_or_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:0] != 8'd0 |-> m_tdata[39:8] == 32'd0)
        else $error("code and value both set");

endmodule

bind per_dim_min_max_sq8_codec sq8_checker u_sq8_checker (.*);
`default_nettype wire
